// ===== src/swbm_pkg.sv =====
// ----------------------------------------------------------------------------
// swbm_pkg
// Shared types and constants for the single-wire byte master.
// ----------------------------------------------------------------------------
`default_nettype none

package swbm_pkg;

  localparam int DATA_BITS_DEF = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD   = 2'd3;

  // Register reset values (ticks)
  localparam logic [CFG_DATA_W-1:0] SHORT_RST  = 8'd10;
  localparam logic [CFG_DATA_W-1:0] LONG_RST   = 8'd50;
  localparam logic [CFG_DATA_W-1:0] SAMPLE_RST = 8'd18;
  localparam logic [CFG_DATA_W-1:0] HOLD_RST   = 8'd15;

  // Tick operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] write_data;
    logic       line_in;
  } in_t;

  typedef struct packed {
    logic       line_drive;
    logic       line_release;
    logic       sample_mark;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_t;

endpackage

`default_nettype wire

// ===== src/single_wire_byte_master_top.sv =====
// ----------------------------------------------------------------------------
// single_wire_byte_master_top
// Tick-stepped master for a custom single-wire link: byte write and read.
// ----------------------------------------------------------------------------
// Each accepted input transfer is one 1 us tick carrying the sampled line
// level and optionally a write or read start (ignored while a sequence runs).
// Every tick yields exactly one result transfer, registered at acceptance
// into the output register or skid; a new tick can be taken every cycle
// while in_stall is low. The phase sequencer and its 8-bit tick counter
// settle in one pass between the input handshake and the result register.
// A two-deep result buffer (output register plus skid) lets input continue
// while one result waits; in_stall rises only when both hold results. Delay
// registers take effect at once, a value of zero gives a 256-tick phase,
// and edge waits have no timeout. No clearing pass after reset.
`default_nettype none

module single_wire_byte_master_top #(
  parameter int DATA_BITS = swbm_pkg::DATA_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  swbm_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output swbm_pkg::out_t                       out_data,
  input  wire                                  cfg_write,
  input  wire  [swbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [swbm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DATA_BITS - 1);

  typedef enum logic [4:0] {
    P_IDLE,
    W_L1, W_H1, W_L2, W_H2,
    WB_L1, WB_H1, WB_L2, WB_D, WB_H,
    WE_L, WE_H,
    R_L1, R_H1, R_H2, R_H3, R_L2, R_H4,
    R_SYNL, R_SYNH, R_BWL, R_BWH, R_SDLY, R_SAMP, R_HDLY, R_BWH2
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE, K_SHORT, K_LONG, K_SAMPLE, K_HOLD
  } kind_t;

  // Delay registers
  logic [7:0] short_delay;
  logic [7:0] long_delay;
  logic [7:0] sample_delay;
  logic [7:0] hold_delay;

  // Sequencer state
  phase_t                 phase;
  logic [7:0]             tick_count;
  logic [IDX_W-1:0]       bit_index;
  logic [DATA_BITS-1:0]   send_shift;
  logic [DATA_BITS-1:0]   receive_shift;
  logic [DATA_BITS-1:0]   last_read;

  phase_t                 phase_next;
  logic [7:0]             tick_count_next;
  logic [IDX_W-1:0]       bit_index_next;
  logic [DATA_BITS-1:0]   send_shift_next;
  logic [DATA_BITS-1:0]   receive_shift_next;
  logic [DATA_BITS-1:0]   last_read_next;
  swbm_pkg::out_t         result;

  // Result buffer
  logic                   skid_valid;
  swbm_pkg::out_t         skid_data;

  logic accept;
  logic out_take;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_comb begin
    phase_t     ph;
    kind_t      kind;
    logic [7:0] limit;
    logic [7:0] tc_inc;
    logic       drive;
    logic       rel;
    logic       mark;
    logic       done;

    ph                 = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    last_read_next     = last_read;
    done               = 1'b0;
    mark               = 1'b0;

    // A start in idle already shows its first phase on this tick
    if (phase == P_IDLE) begin
      if (in_data.op == swbm_pkg::OP_WRITE) begin
        ph              = W_L1;
        send_shift_next = DATA_BITS'(in_data.write_data);
        bit_index_next  = IDX_TOP;
        tick_count_next = 8'd0;
      end else if (in_data.op == swbm_pkg::OP_READ) begin
        ph                 = R_L1;
        receive_shift_next = '0;
        bit_index_next     = IDX_TOP;
        tick_count_next    = 8'd0;
      end
    end

    case (ph)
      W_L1, W_H1, W_L2, W_H2, WB_H,
      R_L1, R_H1, R_H2, R_H3:           kind = K_LONG;
      WB_L1, WB_H1, WB_L2, WB_D,
      WE_L, WE_H, R_L2, R_H4:           kind = K_SHORT;
      R_SDLY:                           kind = K_SAMPLE;
      R_HDLY:                           kind = K_HOLD;
      default:                          kind = K_NONE;
    endcase

    rel   = 1'b0;
    case (ph)
      W_L1, W_L2, WB_L1, WB_L2, WE_L,
      R_L1, R_L2:                       drive = 1'b0;
      WB_D:                             drive = send_shift_next[bit_index_next];
      R_SYNL, R_SYNH, R_BWL, R_BWH,
      R_SDLY, R_SAMP, R_HDLY, R_BWH2: begin
        drive = 1'b1;
        rel   = 1'b1;
      end
      default:                          drive = 1'b1;
    endcase

    if (ph == WB_D || ph == R_SAMP) begin
      mark = 1'b1;
    end

    case (kind)
      K_SHORT:  limit = short_delay;
      K_LONG:   limit = long_delay;
      K_SAMPLE: limit = sample_delay;
      default:  limit = hold_delay;
    endcase

    tc_inc     = tick_count_next + 8'd1;
    phase_next = ph;

    if (kind != K_NONE) begin
      tick_count_next = tc_inc;
      if (tc_inc == limit) begin
        tick_count_next = 8'd0;
        case (ph)
          WB_H: begin
            if (bit_index_next == '0) begin
              phase_next = WE_L;
            end else begin
              bit_index_next = bit_index_next - IDX_W'(1);
              phase_next     = WB_L1;
            end
          end
          WE_H: begin
            done       = 1'b1;
            phase_next = P_IDLE;
          end
          R_H4:    phase_next = R_SYNL;
          R_SDLY:  phase_next = R_SAMP;
          R_HDLY:  phase_next = R_BWH2;
          default: phase_next = phase_t'(5'(ph) + 5'd1);
        endcase
      end
    end else begin
      case (ph)
        R_SYNL: if (in_data.line_in)  phase_next = R_SYNH;
        R_SYNH: if (!in_data.line_in) phase_next = R_BWL;
        R_BWL:  if (in_data.line_in)  phase_next = R_BWH;
        R_BWH: begin
          if (!in_data.line_in) begin
            phase_next      = R_SDLY;
            tick_count_next = 8'd0;
          end
        end
        R_SAMP: begin
          if (in_data.line_in) begin
            receive_shift_next[bit_index_next] = 1'b1;
          end
          phase_next      = R_HDLY;
          tick_count_next = 8'd0;
        end
        R_BWH2: begin
          if (!in_data.line_in) begin
            if (bit_index_next == '0) begin
              last_read_next = receive_shift_next;
              phase_next     = P_IDLE;
              done           = 1'b1;
            end else begin
              bit_index_next = bit_index_next - IDX_W'(1);
              phase_next     = R_BWL;
            end
          end
        end
        default: ;
      endcase
    end

    result.line_drive   = drive;
    result.line_release = rel;
    result.sample_mark  = mark;
    result.busy_res     = (ph != P_IDLE);
    result.done_res     = done;
    result.read_data    = 8'(last_read_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_delay   <= swbm_pkg::SHORT_RST;
      long_delay    <= swbm_pkg::LONG_RST;
      sample_delay  <= swbm_pkg::SAMPLE_RST;
      hold_delay    <= swbm_pkg::HOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        swbm_pkg::REG_SHORT:  short_delay  <= cfg_data;
        swbm_pkg::REG_LONG:   long_delay   <= cfg_data;
        swbm_pkg::REG_SAMPLE: sample_delay <= cfg_data;
        swbm_pkg::REG_HOLD:   hold_delay   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= P_IDLE;
      tick_count    <= 8'd0;
      bit_index     <= IDX_TOP;
      send_shift    <= '0;
      receive_shift <= '0;
      last_read     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      last_read     <= last_read_next;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
        out_data   <= result;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

endmodule

`default_nettype wire

// ===== src/swbm_checker.sv =====
// ----------------------------------------------------------------------------
// swbm_checker
// Port-level checks for the single-wire byte master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swbm_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input swbm_pkg::out_t                   out_data
);

  // A stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A finishing tick is always part of a running sequence
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  // Sample marks and a released line only occur inside a sequence
  a_mark_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.sample_mark || out_data.line_release) |-> out_data.busy_res)
    else $error("mark or release while idle");

  // Released line reports level high
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.line_release |-> out_data.line_drive)
    else $error("released line not shown high");

  // Input is never stalled unless a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind single_wire_byte_master_top swbm_checker u_swbm_checker (.*);

`default_nettype wire
